FILE: hdl/hill_cipher_2x2_codec_assert.svh
// Assertion macros for the Hill cipher codec.
`ifndef HILL_CIPHER_2X2_CODEC_ASSERT_SVH
`define HILL_CIPHER_2X2_CODEC_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HC2_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hill codec: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define HC2_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hill codec: next-cycle check failed");

`endif

FILE: hdl/hc2_pkg.sv
// Types, constants and mod-26 helpers shared by the Hill cipher codec.
package hc2_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned PROD_W      = 2 * LETTER_W;
  localparam int unsigned SUM_W       = 11;
  localparam int unsigned MODULUS     = 26;
  localparam int unsigned PAD_LETTER  = 23;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_R0C0     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_R0C1     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_R1C0     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_R1C1     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 3'd4;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t letter;
    logic    end_of_message;
  } in_item_t;

  typedef struct packed {
    letter_t out_letter;
    logic    last_of_run;
  } out_item_t;

  typedef struct packed {
    letter_t r0c0;
    letter_t r0c1;
    letter_t r1c0;
    letter_t r1c1;
  } key_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
  } pair_t;

  typedef struct packed {
    logic holding;
    logic launch;
  } dp_status_t;

  // Fold a 5-bit value into 0..25
  function automatic letter_t reduce_letter(input letter_t v);
    return (v >= LETTER_W'(MODULUS)) ? v - LETTER_W'(MODULUS) : v;
  endfunction

  // Additive inverse of a reduced letter
  function automatic letter_t negate_letter(input letter_t v);
    return (v == '0) ? '0 : LETTER_W'(MODULUS) - v;
  endfunction

  // Reduce a value below 26*64 into 0..25 by shifted compare-subtract
  function automatic letter_t reduce_sum(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    r = x;
    for (int k = 5; k >= 0; k--) begin
      if (r >= (SUM_W'(MODULUS) << k)) begin
        r = r - (SUM_W'(MODULUS) << k);
      end
    end
    return r[LETTER_W-1:0];
  endfunction

  // Multiplicative inverse mod 26; non-units fall back to 1
  function automatic letter_t inverse_of(input letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hc2_inverse.sv
// Determinant of the key and its inverse mod 26, over three register stages.
module hc2_inverse
  import hc2_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  key_t    key,
  output letter_t det_inv
);

  letter_t a, b, c, d;
  logic [PROD_W-1:0] ad;
  logic [PROD_W-1:0] bc;
  letter_t det;

  always_comb begin
    a = reduce_letter(key.r0c0);
    b = reduce_letter(key.r0c1);
    c = reduce_letter(key.r1c0);
    d = reduce_letter(key.r1c1);
  end

  // Form the cross products, reduce the determinant, look up its inverse
  always_ff @(posedge clk) begin
    if (rst) begin
      ad      <= '0;
      bc      <= '0;
      det     <= '0;
      det_inv <= LETTER_W'(1);
    end else begin
      ad      <= PROD_W'(a) * PROD_W'(d);
      bc      <= PROD_W'(b) * PROD_W'(c);
      det     <= reduce_sum(SUM_W'(ad) + SUM_W'(MODULUS * MODULUS) - SUM_W'(bc));
      det_inv <= inverse_of(det);
    end
  end

endmodule

FILE: hdl/hc2_datapath.sv
// Letter pairing and the pipelined 2x2 matrix product mod 26.
module hc2_datapath
  import hc2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  key_t       key,
  input  logic       decrypt_mode,
  input  letter_t    det_inv,
  output logic       pair_wr,
  output pair_t      pair,
  output dp_status_t status
);

  logic    accept;
  logic    launch;
  letter_t held_letter;
  logic    holding;
  pair_t   new_pair;

  logic    a_valid, b_valid, c_valid, d_valid;
  pair_t   a_pair;
  logic [SUM_W-1:0]  b_sum0, b_sum1;
  letter_t c_res0, c_res1;
  logic [PROD_W-1:0] d_prod0, d_prod1;

  letter_t p0, p1;
  letter_t ka, kb, kc, kd;
  letter_t m0, m1, m2, m3;
  letter_t scale;

  // Pair the incoming letter with the held one or with the pad letter
  always_comb begin
    accept         = in_valid & ~in_stall;
    launch         = accept & (holding | in_data.end_of_message);
    new_pair.first  = holding ? held_letter : in_data.letter;
    new_pair.second = holding ? in_data.letter : LETTER_W'(PAD_LETTER);
  end

  // Hold the first letter of a pair
  always_ff @(posedge clk) begin
    if (rst) begin
      holding     <= 1'b0;
      held_letter <= '0;
    end else if (accept) begin
      if (holding) begin
        holding     <= 1'b0;
        held_letter <= '0;
      end else if (!in_data.end_of_message) begin
        holding     <= 1'b1;
        held_letter <= in_data.letter;
      end
    end
  end

  // Pick the key or its adjugate; the determinant inverse scales later
  always_comb begin
    p0 = reduce_letter(a_pair.first);
    p1 = reduce_letter(a_pair.second);
    ka = reduce_letter(key.r0c0);
    kb = reduce_letter(key.r0c1);
    kc = reduce_letter(key.r1c0);
    kd = reduce_letter(key.r1c1);
    if (decrypt_mode) begin
      m0 = kd;
      m1 = negate_letter(kb);
      m2 = negate_letter(kc);
      m3 = ka;
    end else begin
      m0 = ka;
      m1 = kb;
      m2 = kc;
      m3 = kd;
    end
    scale = decrypt_mode ? det_inv : LETTER_W'(1);
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= launch;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // Pipeline payload: capture, multiply-accumulate, reduce, scale
  always_ff @(posedge clk) begin
    if (launch) begin
      a_pair <= new_pair;
    end
    b_sum0  <= SUM_W'(PROD_W'(m0) * PROD_W'(p0)) + SUM_W'(PROD_W'(m1) * PROD_W'(p1));
    b_sum1  <= SUM_W'(PROD_W'(m2) * PROD_W'(p0)) + SUM_W'(PROD_W'(m3) * PROD_W'(p1));
    c_res0  <= reduce_sum(b_sum0);
    c_res1  <= reduce_sum(b_sum1);
    d_prod0 <= PROD_W'(c_res0) * PROD_W'(scale);
    d_prod1 <= PROD_W'(c_res1) * PROD_W'(scale);
  end

  // Final reduction feeds the result queue
  always_comb begin
    pair_wr        = d_valid;
    pair.first     = reduce_sum(SUM_W'(d_prod0));
    pair.second    = reduce_sum(SUM_W'(d_prod1));
    status.holding = holding;
    status.launch  = launch;
  end

endmodule

FILE: hdl/hc2_out_fifo.sv
// Result pair queue with launch credits; one letter out per cycle unless stalled.
module hc2_out_fifo
  import hc2_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       launch,
  input  logic                       wr_en,
  input  pair_t                      wr_pair,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_data,
  output logic                       can_launch,
  output logic [$clog2(DEPTH+1)-1:0] credit_count,
  output logic [$clog2(DEPTH+1)-1:0] stored_count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pair_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             half;
  logic             take;
  logic             pop;
  pair_t            head;

  always_comb begin
    head                = slots[rd_ptr];
    out_valid           = (stored_count != '0);
    take                = out_valid & ~out_stall;
    pop                 = take & half;
    out_data.out_letter = half ? head.second : head.first;
    out_data.last_of_run = half;
    can_launch          = (credit_count != CNT_W'(DEPTH));
  end

  // Store each finished pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_pair;
    end
  end

  // Advance pointers, counts and the half select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      half         <= 1'b0;
      stored_count <= '0;
      credit_count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (take) begin
        half <= ~half;
      end
      stored_count <= stored_count + CNT_W'(wr_en) - CNT_W'(pop);
      credit_count <= credit_count + CNT_W'(launch) - CNT_W'(pop);
    end
  end

endmodule

FILE: hdl/hill_cipher_2x2_codec.sv
// 2x2 Hill cipher codec mod 26: letters in and out one per cycle unless stalled.
// Pairs pass stages a-d, then the queue; each second letter is offered once its first is taken.
// One letter per cycle each way unless stalled; 4 register stages and FIFO_DEPTH pair credits.
// The input stalls only while FIFO_DEPTH pairs are in flight or queued.
// Decrypt scaling follows a key write through the ad/bc, det and det_inv stages.
// Reset (synchronous): key and mode to zero, no letter held, queue empty, no clearing pass.
`include "hill_cipher_2x2_codec_assert.svh"

module hill_cipher_2x2_codec
  import hc2_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  key_t       key;
  logic       decrypt_mode;
  letter_t    det_inv;
  logic       pair_wr;
  pair_t      pair;
  dp_status_t status;
  logic       can_launch;
  logic       in_accept;
  logic       lone_first;
  logic [CNT_W-1:0] credit_count;
  logic [CNT_W-1:0] stored_count;

  assign in_stall   = ~can_launch;
  assign in_accept  = in_valid & ~in_stall;
  assign lone_first = in_accept & ~status.holding & ~in_data.end_of_message;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_R0C0:     key.r0c0     <= cfg_data;
        REG_KEY_R0C1:     key.r0c1     <= cfg_data;
        REG_KEY_R1C0:     key.r1c0     <= cfg_data;
        REG_KEY_R1C1:     key.r1c1     <= cfg_data;
        REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hc2_inverse u_inverse (
    .clk     (clk),
    .rst     (rst),
    .key     (key),
    .det_inv (det_inv)
  );

  hc2_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .key          (key),
    .decrypt_mode (decrypt_mode),
    .det_inv      (det_inv),
    .pair_wr      (pair_wr),
    .pair         (pair),
    .status       (status)
  );

  hc2_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .launch       (status.launch),
    .wr_en        (pair_wr),
    .wr_pair      (pair),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .can_launch   (can_launch),
    .credit_count (credit_count),
    .stored_count (stored_count)
  );

  // A lone first letter is held; the next letter always releases it
  `HC2_ASSERT_NEXT(a_hold_first, clk, rst, lone_first, status.holding)
  `HC2_ASSERT_NEXT(a_release_pair, clk, rst, in_accept && status.holding, !status.holding)
  // Credits keep the queue from overflowing
  `HC2_ASSERT_IMPLIES(a_no_overflow, clk, rst, pair_wr, stored_count != CNT_W'(FIFO_DEPTH))
  `HC2_ASSERT_IMPLIES(a_credit_cover, clk, rst, 1'b1, stored_count <= credit_count)

endmodule
